// ===== sv/firq15_pkg.sv =====
`default_nettype none

package firq15_pkg;

    localparam int TAPS_DEFAULT      = 30;
    localparam int FRAC_BITS_DEFAULT = 15;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 17;
    localparam int INDEX_W  = 5;
    localparam int ACC_W    = 32;
    localparam int DIGIT_W  = 4;
    localparam int NDIG     = SAMPLE_W / DIGIT_W;
    localparam int DIG_CW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int PROD_W   = COEF_W + DIGIT_W + 1;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_LOAD   = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MAC,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/fir_filter_q15_circular.sv =====
// Direct-form FIR filter on signed 16-bit samples with coefficients in
// fixed point (scaled by 2^FRAC_BITS), over a circular delay line of TAPS.
// Input channel: i_valid / o_stall. A transaction with i_opcode = load
// writes one coefficient at i_coef_index (ignored from TAPS upwards) and
// gives no result. A transaction with i_opcode = filter stores the sample,
// runs the convolution and gives one o_filtered.
// Output channel: o_valid / i_stall, with a single output register.
// For each tap the control reads both tap stores (fetch state), then
// multiplies the coefficient by the sample one 4-bit digit at a time (MAC
// state). After the last tap the done state loads the result into the
// output register and returns to idle, where the next transaction is
// taken; no transaction is accepted while a filter is running.
// A coefficient load is written in idle and leaves the control in idle.
// When the receiver stalls, the result waits in the output register and
// the next transaction is still taken; a later result waits for the
// register to empty, holding the input stalled meanwhile.
// Synchronous reset clears the tap stores (by per-entry valid bits), the
// write pointer, the control and the output valid flag.

`default_nettype none

module fir_filter_q15_circular #(
    parameter int TAPS      = firq15_pkg::TAPS_DEFAULT,
    parameter int FRAC_BITS = firq15_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic                                   i_opcode,
    input  wire logic signed [firq15_pkg::SAMPLE_W-1:0] i_sample_value,
    input  wire logic        [firq15_pkg::INDEX_W-1:0]  i_coef_index,
    input  wire logic signed [firq15_pkg::COEF_W-1:0]   i_coef_value,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [firq15_pkg::SAMPLE_W-1:0]      o_filtered
);

    localparam int PW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W  = firq15_pkg::ACC_W;
    localparam int PROD_W = firq15_pkg::PROD_W;
    localparam int DIG_W  = firq15_pkg::DIGIT_W;
    localparam int DIG_CW = firq15_pkg::DIG_CW;

    firq15_pkg::t_state r_state, n_state;

    logic signed [firq15_pkg::SAMPLE_W-1:0] r_delay_mem [TAPS];
    logic signed [firq15_pkg::COEF_W-1:0]   r_coef_mem  [TAPS];
    logic [TAPS-1:0]                        r_dvalid;
    logic [TAPS-1:0]                        r_cvalid;

    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_k;
    logic [PW-1:0]     r_tap;
    logic [DIG_CW-1:0] r_dig;
    logic [ACC_W-1:0]  r_acc, n_acc;

    logic signed [firq15_pkg::COEF_W-1:0] r_coef_q;
    logic [firq15_pkg::SAMPLE_W-1:0]      r_samp_q;

    logic                                   r_out_valid;
    logic signed [firq15_pkg::SAMPLE_W-1:0] r_out_data;

    logic in_acc, acc_filter, acc_load, load_ok;
    logic c_fetch, c_mac, c_done_ld, out_free;
    logic last_dig, last_tap;

    logic signed [DIG_W:0]   digit;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]        prod_ext;
    logic [ACC_W:0]          bias;
    logic signed [ACC_W:0]   biased;
    logic signed [ACC_W:0]   quo;

    assign in_acc     = i_valid && !o_stall;
    assign acc_filter = in_acc && (i_opcode == firq15_pkg::OP_FILTER);
    assign acc_load   = in_acc && (i_opcode == firq15_pkg::OP_LOAD);
    assign load_ok    = (32'(i_coef_index) < TAPS);
    assign out_free   = !r_out_valid || !i_stall;
    assign last_dig   = (r_dig == DIG_CW'(firq15_pkg::NDIG - 1));
    assign last_tap   = (r_tap == PW'(TAPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            firq15_pkg::ST_IDLE: begin
                if (acc_filter) n_state = firq15_pkg::ST_FETCH;
            end
            firq15_pkg::ST_FETCH: begin
                n_state = firq15_pkg::ST_MAC;
            end
            firq15_pkg::ST_MAC: begin
                if (last_dig) begin
                    n_state = last_tap ? firq15_pkg::ST_DONE : firq15_pkg::ST_FETCH;
                end
            end
            firq15_pkg::ST_DONE: begin
                if (out_free) n_state = firq15_pkg::ST_IDLE;
            end
            default: n_state = firq15_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall   = 1'b1;
        c_fetch   = 1'b0;
        c_mac     = 1'b0;
        c_done_ld = 1'b0;
        unique case (r_state)
            firq15_pkg::ST_IDLE:  o_stall   = 1'b0;
            firq15_pkg::ST_FETCH: c_fetch   = 1'b1;
            firq15_pkg::ST_MAC:   c_mac     = 1'b1;
            firq15_pkg::ST_DONE:  c_done_ld = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= firq15_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_filter) begin
            r_delay_mem[r_wp] <= i_sample_value;
        end
        if (acc_load && load_ok) begin
            r_coef_mem[PW'(i_coef_index)] <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
            r_cvalid <= '0;
        end else begin
            if (acc_filter) r_dvalid[r_wp] <= 1'b1;
            if (acc_load && load_ok) r_cvalid[PW'(i_coef_index)] <= 1'b1;
        end
    end

    // read both stores, then shift the sample out one digit per cycle
    always_ff @(posedge i_clk) begin
        if (c_fetch) begin
            r_coef_q <= r_cvalid[r_tap] ? r_coef_mem[r_tap] : '0;
            r_samp_q <= r_dvalid[r_k] ? r_delay_mem[r_k] : '0;
        end else if (c_mac) begin
            r_samp_q <= r_samp_q >> DIG_W;
        end
    end

    always_comb begin
        if (last_dig) begin
            digit = signed'({r_samp_q[DIG_W-1], r_samp_q[DIG_W-1:0]});
        end else begin
            digit = signed'({1'b0, r_samp_q[DIG_W-1:0]});
        end
        prod     = PROD_W'(r_coef_q * digit);
        prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
        n_acc    = r_acc + (prod_ext << (32'(r_dig) * DIG_W));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_k   <= '0;
            r_tap <= '0;
            r_dig <= '0;
            r_acc <= '0;
        end else if (acc_filter) begin
            r_wp  <= (r_wp == PW'(TAPS - 1)) ? '0 : PW'(r_wp + 1'b1);
            r_k   <= r_wp;
            r_tap <= '0;
            r_dig <= '0;
            r_acc <= '0;
        end else if (c_mac) begin
            r_acc <= n_acc;
            r_dig <= last_dig ? '0 : DIG_CW'(r_dig + 1'b1);
            if (last_dig) begin
                r_tap <= PW'(r_tap + 1'b1);
                r_k   <= (r_k == '0) ? PW'(TAPS - 1) : PW'(r_k - 1'b1);
            end
        end
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    always_comb begin
        bias   = r_acc[ACC_W-1] ? (ACC_W+1)'((64'd1 << FRAC_BITS) - 64'd1) : '0;
        biased = signed'({r_acc[ACC_W-1], r_acc} + bias);
        quo    = biased >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_done_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_done_ld) begin
            r_out_data <= quo[firq15_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_data;

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wp) < TAPS)
        else $error("write pointer beyond tap count");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == firq15_pkg::ST_DONE))
        else $error("result raised outside completion");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_load && !r_out_valid) |=> !r_out_valid)
        else $error("coefficient load produced a result");

    a_mac_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_mac || c_fetch) |-> (32'(r_tap) < TAPS && 32'(r_k) < TAPS))
        else $error("tap index beyond tap count");

endmodule

`default_nettype wire
